// ----- hdl/r2k_pkg.sv -----
// Shared types, constants and romaji key tables for the romaji-to-kana stream unit.
// No dependencies.
`default_nettype none
package r2k_pkg;

   typedef logic [15:0] unit_type;

   typedef struct packed {
      unit_type unit;
      logic     last;
   } beat_type;

   typedef struct packed {
      logic     hit;
      unit_type k0;
      unit_type k1;
   } kana_type;

   typedef struct packed {
      logic [1:0] n_emit;
      unit_type   u0;
      unit_type   u1;
      logic [1:0] used;
      logic       bare_n;
   } tok_res_type;

   localparam unit_type KANA_CHOON     = 16'h30FC;
   localparam unit_type KANA_SMALL_TSU = 16'h3063;
   localparam unit_type KANA_N         = 16'h3093;
   localparam unit_type ASCII_HYPHEN   = 16'h002D;
   localparam unit_type ASCII_N        = 16'h006E;
   localparam unit_type ASCII_LOW_A    = 16'h0061;
   localparam unit_type ASCII_LOW_Z    = 16'h007A;
   localparam unit_type ASCII_UP_A     = 16'h0041;
   localparam unit_type ASCII_UP_Z     = 16'h005A;

   function automatic unit_type fold_case(input unit_type c);
      unit_type r;
      r = c;
      if (c >= ASCII_UP_A && c <= ASCII_UP_Z) begin
         r = c + 16'h0020;
      end
      return r;
   endfunction

   function automatic logic is_doubling(input unit_type c);
      logic r;
      r = (c >= ASCII_LOW_A) && (c <= ASCII_LOW_Z);
      case (c[7:0])
         "a", "i", "u", "e", "o", "n": r = 1'b0;
         default: ;
      endcase
      return r;
   endfunction

   function automatic kana_type key1(input logic [7:0] c0);
      kana_type r;
      r = '{hit: 1'b1, k0: 16'h0000, k1: 16'h0000};
      case (c0)
         "a": r.k0 = 16'h3042;
         "i": r.k0 = 16'h3044;
         "u": r.k0 = 16'h3046;
         "e": r.k0 = 16'h3048;
         "o": r.k0 = 16'h304A;
         "n": r.k0 = 16'h3093;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic kana_type key2(input logic [15:0] c);
      kana_type r;
      r = '{hit: 1'b1, k0: 16'h0000, k1: 16'h0000};
      case (c)
         "ka": r.k0 = 16'h304B;  "ki": r.k0 = 16'h304D;  "ku": r.k0 = 16'h304F;
         "ke": r.k0 = 16'h3051;  "ko": r.k0 = 16'h3053;
         "sa": r.k0 = 16'h3055;  "si": r.k0 = 16'h3057;  "su": r.k0 = 16'h3059;
         "se": r.k0 = 16'h305B;  "so": r.k0 = 16'h305D;
         "ta": r.k0 = 16'h305F;  "ti": r.k0 = 16'h3061;  "tu": r.k0 = 16'h3064;
         "te": r.k0 = 16'h3066;  "to": r.k0 = 16'h3068;
         "na": r.k0 = 16'h306A;  "ni": r.k0 = 16'h306B;  "nu": r.k0 = 16'h306C;
         "ne": r.k0 = 16'h306D;  "no": r.k0 = 16'h306E;
         "ha": r.k0 = 16'h306F;  "hi": r.k0 = 16'h3072;  "fu": r.k0 = 16'h3075;
         "hu": r.k0 = 16'h3075;  "he": r.k0 = 16'h3078;  "ho": r.k0 = 16'h307B;
         "ma": r.k0 = 16'h307E;  "mi": r.k0 = 16'h307F;  "mu": r.k0 = 16'h3080;
         "me": r.k0 = 16'h3081;  "mo": r.k0 = 16'h3082;
         "ya": r.k0 = 16'h3084;  "yu": r.k0 = 16'h3086;  "yo": r.k0 = 16'h3088;
         "ra": r.k0 = 16'h3089;  "ri": r.k0 = 16'h308A;  "ru": r.k0 = 16'h308B;
         "re": r.k0 = 16'h308C;  "ro": r.k0 = 16'h308D;
         "wa": r.k0 = 16'h308F;  "wo": r.k0 = 16'h3092;
         "ga": r.k0 = 16'h304C;  "gi": r.k0 = 16'h304E;  "gu": r.k0 = 16'h3050;
         "ge": r.k0 = 16'h3052;  "go": r.k0 = 16'h3054;
         "za": r.k0 = 16'h3056;  "ji": r.k0 = 16'h3058;  "zi": r.k0 = 16'h3058;
         "zu": r.k0 = 16'h305A;  "ze": r.k0 = 16'h305C;  "zo": r.k0 = 16'h305E;
         "da": r.k0 = 16'h3060;  "di": r.k0 = 16'h3062;  "du": r.k0 = 16'h3065;
         "de": r.k0 = 16'h3067;  "do": r.k0 = 16'h3069;
         "ba": r.k0 = 16'h3070;  "bi": r.k0 = 16'h3073;  "bu": r.k0 = 16'h3076;
         "be": r.k0 = 16'h3079;  "bo": r.k0 = 16'h307C;
         "pa": r.k0 = 16'h3071;  "pi": r.k0 = 16'h3074;  "pu": r.k0 = 16'h3077;
         "pe": r.k0 = 16'h307A;  "po": r.k0 = 16'h307D;
         "ja": begin r.k0 = 16'h3058; r.k1 = 16'h3083; end
         "ju": begin r.k0 = 16'h3058; r.k1 = 16'h3085; end
         "jo": begin r.k0 = 16'h3058; r.k1 = 16'h3087; end
         "ye": begin r.k0 = 16'h3044; r.k1 = 16'h3047; end
         "wi": begin r.k0 = 16'h3046; r.k1 = 16'h3043; end
         "we": begin r.k0 = 16'h3046; r.k1 = 16'h3047; end
         "va": begin r.k0 = 16'h3094; r.k1 = 16'h3041; end
         "vi": begin r.k0 = 16'h3094; r.k1 = 16'h3043; end
         "vu": r.k0 = 16'h3094;
         "ve": begin r.k0 = 16'h3094; r.k1 = 16'h3047; end
         "vo": begin r.k0 = 16'h3094; r.k1 = 16'h3049; end
         "je": begin r.k0 = 16'h3058; r.k1 = 16'h3047; end
         "fa": begin r.k0 = 16'h3075; r.k1 = 16'h3041; end
         "fi": begin r.k0 = 16'h3075; r.k1 = 16'h3043; end
         "fe": begin r.k0 = 16'h3075; r.k1 = 16'h3047; end
         "fo": begin r.k0 = 16'h3075; r.k1 = 16'h3049; end
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic kana_type key3(input logic [23:0] c);
      kana_type r;
      r = '{hit: 1'b1, k0: 16'h0000, k1: 16'h0000};
      case (c)
         "shi": r.k0 = 16'h3057;
         "chi": r.k0 = 16'h3061;
         "tsu": r.k0 = 16'h3064;
         "kya": begin r.k0 = 16'h304D; r.k1 = 16'h3083; end
         "kyu": begin r.k0 = 16'h304D; r.k1 = 16'h3085; end
         "kyo": begin r.k0 = 16'h304D; r.k1 = 16'h3087; end
         "sha", "sya": begin r.k0 = 16'h3057; r.k1 = 16'h3083; end
         "shu", "syu": begin r.k0 = 16'h3057; r.k1 = 16'h3085; end
         "sho", "syo": begin r.k0 = 16'h3057; r.k1 = 16'h3087; end
         "cha", "tya": begin r.k0 = 16'h3061; r.k1 = 16'h3083; end
         "chu", "tyu": begin r.k0 = 16'h3061; r.k1 = 16'h3085; end
         "cho", "tyo": begin r.k0 = 16'h3061; r.k1 = 16'h3087; end
         "nya": begin r.k0 = 16'h306B; r.k1 = 16'h3083; end
         "nyu": begin r.k0 = 16'h306B; r.k1 = 16'h3085; end
         "nyo": begin r.k0 = 16'h306B; r.k1 = 16'h3087; end
         "hya": begin r.k0 = 16'h3072; r.k1 = 16'h3083; end
         "hyu": begin r.k0 = 16'h3072; r.k1 = 16'h3085; end
         "hyo": begin r.k0 = 16'h3072; r.k1 = 16'h3087; end
         "mya": begin r.k0 = 16'h307F; r.k1 = 16'h3083; end
         "myu": begin r.k0 = 16'h307F; r.k1 = 16'h3085; end
         "myo": begin r.k0 = 16'h307F; r.k1 = 16'h3087; end
         "rya": begin r.k0 = 16'h308A; r.k1 = 16'h3083; end
         "ryu": begin r.k0 = 16'h308A; r.k1 = 16'h3085; end
         "ryo": begin r.k0 = 16'h308A; r.k1 = 16'h3087; end
         "gya": begin r.k0 = 16'h304E; r.k1 = 16'h3083; end
         "gyu": begin r.k0 = 16'h304E; r.k1 = 16'h3085; end
         "gyo": begin r.k0 = 16'h304E; r.k1 = 16'h3087; end
         "zya", "jya": begin r.k0 = 16'h3058; r.k1 = 16'h3083; end
         "zyu", "jyu": begin r.k0 = 16'h3058; r.k1 = 16'h3085; end
         "zyo", "jyo": begin r.k0 = 16'h3058; r.k1 = 16'h3087; end
         "dya": begin r.k0 = 16'h3062; r.k1 = 16'h3083; end
         "dyu": begin r.k0 = 16'h3062; r.k1 = 16'h3085; end
         "dyo": begin r.k0 = 16'h3062; r.k1 = 16'h3087; end
         "bya": begin r.k0 = 16'h3073; r.k1 = 16'h3083; end
         "byu": begin r.k0 = 16'h3073; r.k1 = 16'h3085; end
         "byo": begin r.k0 = 16'h3073; r.k1 = 16'h3087; end
         "pya": begin r.k0 = 16'h3074; r.k1 = 16'h3083; end
         "pyu": begin r.k0 = 16'h3074; r.k1 = 16'h3085; end
         "pyo": begin r.k0 = 16'h3074; r.k1 = 16'h3087; end
         "she": begin r.k0 = 16'h3057; r.k1 = 16'h3047; end
         "che": begin r.k0 = 16'h3061; r.k1 = 16'h3047; end
         "tsa": begin r.k0 = 16'h3064; r.k1 = 16'h3041; end
         "tsi": begin r.k0 = 16'h3064; r.k1 = 16'h3043; end
         "tse": begin r.k0 = 16'h3064; r.k1 = 16'h3047; end
         "tso": begin r.k0 = 16'h3064; r.k1 = 16'h3049; end
         "fyu": begin r.k0 = 16'h3075; r.k1 = 16'h3085; end
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/r2k_token.sv -----
// Token decoder: takes one token off the head of the lookahead window.
// Depends on r2k_pkg.
`default_nettype none
module r2k_token
   import r2k_pkg::*;
(
   input  var unit_type    w0,
   input  var unit_type    w1,
   input  var unit_type    w2,
   input  var logic [1:0]  count,
   input  var logic        prev_bare_n,
   output tok_res_type     res
);

   unit_type l0, l1, l2;
   logic     ascii0, ascii1, ascii2;
   kana_type k1, k2, k3;
   logic     dbl, hit1, hit2, hit3;

   always_comb begin
      l0 = fold_case(w0);
      l1 = fold_case(w1);
      l2 = fold_case(w2);
      ascii0 = (l0[15:8] == 8'h00);
      ascii1 = (l1[15:8] == 8'h00);
      ascii2 = (l2[15:8] == 8'h00);
      k1 = key1(l0[7:0]);
      k2 = key2({l0[7:0], l1[7:0]});
      k3 = key3({l0[7:0], l1[7:0], l2[7:0]});
      dbl  = (count >= 2'd2) && (l0 == l1) && is_doubling(l0);
      hit3 = (count == 2'd3) && ascii0 && ascii1 && ascii2 && k3.hit;
      hit2 = (count >= 2'd2) && ascii0 && ascii1 && k2.hit;
      hit1 = ascii0 && k1.hit;

      res = '{n_emit: 2'd1, u0: w0, u1: 16'h0000, used: 2'd1, bare_n: 1'b0};
      if (dbl) begin
         res.u0 = KANA_SMALL_TSU;
      end else if (hit3) begin
         res.used = 2'd3;
         res.u0 = k3.k0;
         res.u1 = k3.k1;
         res.n_emit = (k3.k1 != 16'h0000) ? 2'd2 : 2'd1;
      end else if (hit2) begin
         res.used = 2'd2;
         res.u0 = k2.k0;
         res.u1 = k2.k1;
         res.n_emit = (k2.k1 != 16'h0000) ? 2'd2 : 2'd1;
      end else if (hit1) begin
         res.u0 = k1.k0;
         if (l0 == ASCII_N) begin
            // drop a bare n that follows a bare n
            res.bare_n = 1'b1;
            res.n_emit = prev_bare_n ? 2'd0 : 2'd1;
         end
      end else if (w0 == ASCII_HYPHEN) begin
         res.u0 = KANA_CHOON;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/r2k_outq.sv -----
// Result queue: four beats, takes up to two beats per cycle, hands out one when rsp_stall is low.
// Depends on r2k_pkg.
`default_nettype none
module r2k_outq
   import r2k_pkg::*;
(
   input  var logic       clock,
   input  var logic       reset,
   input  var logic [1:0] push_n,
   input  var beat_type   push_d0,
   input  var beat_type   push_d1,
   output logic [2:0]     fill,
   output logic           rsp_valid,
   input  var logic       rsp_stall,
   output beat_type       head
);

   beat_type   mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign head      = mem_ff[rp_ff];
   assign fill      = cnt_ff;
   assign cnt_in    = cnt_ff + {1'b0, push_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wp_ff] <= push_d0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wp_ff + 2'd1] <= push_d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff + push_n;
         rp_ff  <= rp_ff + {1'b0, pop};
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/romaji_to_kana_stream_unit.sv -----
// Top level of the romaji-to-hiragana stream converter.
// Depends on r2k_pkg, r2k_token and r2k_outq.
`default_nettype none
// Converts a stream of UTF-16 code units, typed as romaji, into hiragana.
// Each input beat is appended to a three-unit lookahead window; each token
// taken from the window (small tsu for a doubled consonant, the longest romaji
// key of up to three letters, or a passed-through unit) is processed while the
// window takes no new beat, and after the end-of-text beat the tokens left in
// the window are taken before a closing step ends the string. Tokens emit up
// to two units into a four-beat result queue; a token is processed only when
// two queue slots are free, so rsp_stall backs up into req_stall.
// Letters compare case-blind, '-' becomes the long-vowel mark, and a run of
// bare n gives a single n-kana. During the end-of-text flush the newest result
// is held back one token so that the true final unit of the string can carry
// rsp_last_unit; a string whose flush emits nothing gets no last marker.
module romaji_to_kana_stream_unit
   import r2k_pkg::*;
(
   input  var logic     clock,
   input  var logic     reset,
   input  var logic     req_valid,
   output logic         req_stall,
   input  var unit_type req_code_unit,
   input  var logic     req_end_of_text,
   output logic         rsp_valid,
   input  var logic     rsp_stall,
   output unit_type     rsp_out_unit,
   output logic         rsp_last_unit
);

   unit_type    w_ff [3];
   unit_type    w_in [3];
   logic [1:0]  cnt_ff, cnt_in;
   logic        flush_ff, flush_in;
   logic        bare_n_ff, bare_n_in;
   logic        hold_v_ff, hold_v_in;
   unit_type    hold_ff, hold_in;
   logic [1:0]  push_n;
   beat_type    push_d0, push_d1, head;
   logic [2:0]  fill;
   logic        room, accept, tok_go, close_go;
   tok_res_type tok;

   r2k_token u_token (
      .w0          (w_ff[0]),
      .w1          (w_ff[1]),
      .w2          (w_ff[2]),
      .count       (cnt_ff),
      .prev_bare_n (bare_n_ff),
      .res         (tok)
   );

   r2k_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_d0   (push_d0),
      .push_d1   (push_d1),
      .fill      (fill),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_out_unit  = head.unit;
   assign rsp_last_unit = head.last;

   // window takes a beat only when no token is waiting
   assign room      = (fill <= 3'd2);
   assign req_stall = flush_ff || (cnt_ff == 2'd3);
   assign accept    = req_valid && !req_stall;
   assign tok_go    = room && ((cnt_ff == 2'd3) || (flush_ff && cnt_ff != 2'd0));
   assign close_go  = room && flush_ff && (cnt_ff == 2'd0);

   always_comb begin
      w_in      = w_ff;
      cnt_in    = cnt_ff;
      flush_in  = flush_ff;
      bare_n_in = bare_n_ff;
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      push_n    = 2'd0;
      push_d0   = '{unit: tok.u0, last: 1'b0};
      push_d1   = '{unit: tok.u1, last: 1'b0};

      if (accept) begin
         // append the beat at the tail
         case (cnt_ff)
            2'd0:    w_in[0] = req_code_unit;
            2'd1:    w_in[1] = req_code_unit;
            default: w_in[2] = req_code_unit;
         endcase
         cnt_in   = cnt_ff + 2'd1;
         flush_in = req_end_of_text;
      end else if (tok_go) begin
         bare_n_in = tok.bare_n;
         cnt_in    = cnt_ff - tok.used;
         case (tok.used)
            2'd1: begin
               w_in[0] = w_ff[1];
               w_in[1] = w_ff[2];
            end
            2'd2:    w_in[0] = w_ff[2];
            default: ;
         endcase
         if (!flush_ff) begin
            push_n = tok.n_emit;
         end else if (tok.n_emit != 2'd0) begin
            // hold the newest unit back; advance the older ones
            hold_v_in = 1'b1;
            hold_in   = (tok.n_emit == 2'd2) ? tok.u1 : tok.u0;
            if (hold_v_ff) begin
               push_d0 = '{unit: hold_ff, last: 1'b0};
               push_d1 = '{unit: tok.u0, last: 1'b0};
               push_n  = (tok.n_emit == 2'd2) ? 2'd2 : 2'd1;
            end else begin
               push_n  = (tok.n_emit == 2'd2) ? 2'd1 : 2'd0;
            end
         end
      end else if (close_go) begin
         // end of string: release the held unit as the last beat
         push_d0   = '{unit: hold_ff, last: 1'b1};
         push_n    = hold_v_ff ? 2'd1 : 2'd0;
         hold_v_in = 1'b0;
         flush_in  = 1'b0;
         bare_n_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      hold_ff <= hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         flush_ff  <= 1'b0;
         bare_n_ff <= 1'b0;
         hold_v_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         flush_ff  <= flush_in;
         bare_n_ff <= bare_n_in;
         hold_v_ff <= hold_v_in;
      end
   end

endmodule
`default_nettype wire

// ----- sim/r2k_stream_checker.sv -----
// Checker for the romaji-to-kana stream unit: watches both channels, predicts kana beats.
// Depends on r2k_pkg for the beat type and the kana and ASCII constants.
`default_nettype none
module r2k_stream_checker
   import r2k_pkg::*;
(
   input  var logic     clock,
   input  var logic     reset,
   input  var logic     req_valid,
   input  var logic     req_stall,
   input  var unit_type req_code_unit,
   input  var logic     req_end_of_text,
   input  var logic     rsp_valid,
   input  var logic     rsp_stall,
   input  var unit_type rsp_out_unit,
   input  var logic     rsp_last_unit,
   output int           mismatch_count,
   output int           pending_kana
);

   unit_type window_q [3];
   int       window_fill;
   bit       after_bare_n;
   beat_type kana_q [$];

   assign pending_kana = kana_q.size();

   function automatic unit_type lower_ascii(input unit_type c);
      if (c >= 16'h0041 && c <= 16'h005A) begin
         return c + 16'h0020;
      end
      return c;
   endfunction

   function automatic bit is_geminate(input unit_type c);
      if (c < ASCII_LOW_A || c > ASCII_LOW_Z) begin
         return 1'b0;
      end
      return !(c == "a" || c == "i" || c == "u" || c == "e" || c == "o" || c == "n");
   endfunction

   // Hiragana for one romaji key; k1 is zero when only one unit is emitted.
   function automatic bit romaji_kana(input string key, output unit_type k0,
                                      output unit_type k1);
      k0 = 16'h0000;
      k1 = 16'h0000;
      case (key)
         "a": k0 = 16'h3042;  "i": k0 = 16'h3044;  "u": k0 = 16'h3046;
         "e": k0 = 16'h3048;  "o": k0 = 16'h304A;  "n": k0 = KANA_N;
         "ka": k0 = 16'h304B; "ki": k0 = 16'h304D; "ku": k0 = 16'h304F;
         "ke": k0 = 16'h3051; "ko": k0 = 16'h3053;
         "sa": k0 = 16'h3055; "shi", "si": k0 = 16'h3057; "su": k0 = 16'h3059;
         "se": k0 = 16'h305B; "so": k0 = 16'h305D;
         "ta": k0 = 16'h305F; "chi", "ti": k0 = 16'h3061; "tsu", "tu": k0 = 16'h3064;
         "te": k0 = 16'h3066; "to": k0 = 16'h3068;
         "na": k0 = 16'h306A; "ni": k0 = 16'h306B; "nu": k0 = 16'h306C;
         "ne": k0 = 16'h306D; "no": k0 = 16'h306E;
         "ha": k0 = 16'h306F; "hi": k0 = 16'h3072; "fu", "hu": k0 = 16'h3075;
         "he": k0 = 16'h3078; "ho": k0 = 16'h307B;
         "ma": k0 = 16'h307E; "mi": k0 = 16'h307F; "mu": k0 = 16'h3080;
         "me": k0 = 16'h3081; "mo": k0 = 16'h3082;
         "ya": k0 = 16'h3084; "yu": k0 = 16'h3086; "yo": k0 = 16'h3088;
         "ra": k0 = 16'h3089; "ri": k0 = 16'h308A; "ru": k0 = 16'h308B;
         "re": k0 = 16'h308C; "ro": k0 = 16'h308D;
         "wa": k0 = 16'h308F; "wo": k0 = 16'h3092;
         "ga": k0 = 16'h304C; "gi": k0 = 16'h304E; "gu": k0 = 16'h3050;
         "ge": k0 = 16'h3052; "go": k0 = 16'h3054;
         "za": k0 = 16'h3056; "ji", "zi": k0 = 16'h3058; "zu": k0 = 16'h305A;
         "ze": k0 = 16'h305C; "zo": k0 = 16'h305E;
         "da": k0 = 16'h3060; "di": k0 = 16'h3062; "du": k0 = 16'h3065;
         "de": k0 = 16'h3067; "do": k0 = 16'h3069;
         "ba": k0 = 16'h3070; "bi": k0 = 16'h3073; "bu": k0 = 16'h3076;
         "be": k0 = 16'h3079; "bo": k0 = 16'h307C;
         "pa": k0 = 16'h3071; "pi": k0 = 16'h3074; "pu": k0 = 16'h3077;
         "pe": k0 = 16'h307A; "po": k0 = 16'h307D;
         "vu": k0 = 16'h3094;
         "kya": {k0, k1} = {16'h304D, 16'h3083};
         "kyu": {k0, k1} = {16'h304D, 16'h3085};
         "kyo": {k0, k1} = {16'h304D, 16'h3087};
         "sha", "sya": {k0, k1} = {16'h3057, 16'h3083};
         "shu", "syu": {k0, k1} = {16'h3057, 16'h3085};
         "sho", "syo": {k0, k1} = {16'h3057, 16'h3087};
         "cha", "tya": {k0, k1} = {16'h3061, 16'h3083};
         "chu", "tyu": {k0, k1} = {16'h3061, 16'h3085};
         "cho", "tyo": {k0, k1} = {16'h3061, 16'h3087};
         "nya": {k0, k1} = {16'h306B, 16'h3083};
         "nyu": {k0, k1} = {16'h306B, 16'h3085};
         "nyo": {k0, k1} = {16'h306B, 16'h3087};
         "hya": {k0, k1} = {16'h3072, 16'h3083};
         "hyu": {k0, k1} = {16'h3072, 16'h3085};
         "hyo": {k0, k1} = {16'h3072, 16'h3087};
         "mya": {k0, k1} = {16'h307F, 16'h3083};
         "myu": {k0, k1} = {16'h307F, 16'h3085};
         "myo": {k0, k1} = {16'h307F, 16'h3087};
         "rya": {k0, k1} = {16'h308A, 16'h3083};
         "ryu": {k0, k1} = {16'h308A, 16'h3085};
         "ryo": {k0, k1} = {16'h308A, 16'h3087};
         "gya": {k0, k1} = {16'h304E, 16'h3083};
         "gyu": {k0, k1} = {16'h304E, 16'h3085};
         "gyo": {k0, k1} = {16'h304E, 16'h3087};
         "ja", "zya", "jya": {k0, k1} = {16'h3058, 16'h3083};
         "ju", "zyu", "jyu": {k0, k1} = {16'h3058, 16'h3085};
         "jo", "zyo", "jyo": {k0, k1} = {16'h3058, 16'h3087};
         "dya": {k0, k1} = {16'h3062, 16'h3083};
         "dyu": {k0, k1} = {16'h3062, 16'h3085};
         "dyo": {k0, k1} = {16'h3062, 16'h3087};
         "bya": {k0, k1} = {16'h3073, 16'h3083};
         "byu": {k0, k1} = {16'h3073, 16'h3085};
         "byo": {k0, k1} = {16'h3073, 16'h3087};
         "pya": {k0, k1} = {16'h3074, 16'h3083};
         "pyu": {k0, k1} = {16'h3074, 16'h3085};
         "pyo": {k0, k1} = {16'h3074, 16'h3087};
         "ye": {k0, k1} = {16'h3044, 16'h3047};
         "wi": {k0, k1} = {16'h3046, 16'h3043};
         "we": {k0, k1} = {16'h3046, 16'h3047};
         "va": {k0, k1} = {16'h3094, 16'h3041};
         "vi": {k0, k1} = {16'h3094, 16'h3043};
         "ve": {k0, k1} = {16'h3094, 16'h3047};
         "vo": {k0, k1} = {16'h3094, 16'h3049};
         "she": {k0, k1} = {16'h3057, 16'h3047};
         "je": {k0, k1} = {16'h3058, 16'h3047};
         "che": {k0, k1} = {16'h3061, 16'h3047};
         "tsa": {k0, k1} = {16'h3064, 16'h3041};
         "tsi": {k0, k1} = {16'h3064, 16'h3043};
         "tse": {k0, k1} = {16'h3064, 16'h3047};
         "tso": {k0, k1} = {16'h3064, 16'h3049};
         "fa": {k0, k1} = {16'h3075, 16'h3041};
         "fi": {k0, k1} = {16'h3075, 16'h3043};
         "fe": {k0, k1} = {16'h3075, 16'h3047};
         "fo": {k0, k1} = {16'h3075, 16'h3049};
         "fyu": {k0, k1} = {16'h3075, 16'h3085};
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Append one unit to the window and queue the kana beats it releases.
   function automatic void convert_unit(input unit_type u, input logic eot);
      unit_type lw [3];
      unit_type k0, k1;
      beat_type out_q [$];
      string    key;
      int       used, key_len;
      bit       ascii_ok;
      window_q[window_fill] = u;
      window_fill++;
      while (window_fill == 3 || (eot && window_fill > 0)) begin
         for (int k = 0; k < 3; k++) begin
            lw[k] = (k < window_fill) ? lower_ascii(window_q[k]) : 16'h0000;
         end
         used = 1;
         if (window_fill >= 2 && lw[0] == lw[1] && is_geminate(lw[0])) begin
            out_q.insert(out_q.size(), '{unit: KANA_SMALL_TSU, last: 1'b0});
            after_bare_n = 1'b0;
         end else begin
            key_len = 0;
            for (int len = 3; len >= 1; len--) begin
               if (key_len == 0 && len <= window_fill) begin
                  key = "";
                  ascii_ok = 1'b1;
                  for (int j = 0; j < len; j++) begin
                     if (lw[j][15:8] != 8'h00 || lw[j][7:0] == 8'h00) ascii_ok = 1'b0;
                     else key = {key, string'(lw[j][7:0])};
                  end
                  if (ascii_ok && romaji_kana(key, k0, k1)) key_len = len;
               end
            end
            if (key_len > 0) begin
               used = key_len;
               if (key_len == 1 && lw[0] == ASCII_N) begin
                  // drop a bare n that follows another bare n
                  if (!after_bare_n) out_q.insert(out_q.size(), '{unit: KANA_N, last: 1'b0});
                  after_bare_n = 1'b1;
               end else begin
                  out_q.insert(out_q.size(), '{unit: k0, last: 1'b0});
                  if (k1 != 16'h0000) out_q.insert(out_q.size(), '{unit: k1, last: 1'b0});
                  after_bare_n = 1'b0;
               end
            end else begin
               out_q.insert(out_q.size(), '{unit: (window_q[0] == ASCII_HYPHEN) ? KANA_CHOON
                                                 : window_q[0], last: 1'b0});
               after_bare_n = 1'b0;
            end
         end
         for (int k = 0; k + used < window_fill; k++) begin
            window_q[k] = window_q[k + used];
         end
         window_fill -= used;
      end
      if (eot) begin
         after_bare_n = 1'b0;
         if (out_q.size() > 0) out_q[out_q.size() - 1].last = 1'b1;
      end
      foreach (out_q[i]) kana_q.insert(kana_q.size(), out_q[i]);
   endfunction

   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         window_fill    = 0;
         after_bare_n   = 1'b0;
         mismatch_count <= 0;
         kana_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (kana_q.size() == 0) begin
               $display("%0t: unexpected beat: expected none, actual unit %h last %b",
                        $time, rsp_out_unit, rsp_last_unit);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = kana_q.pop_front();
               if (want.unit !== rsp_out_unit || want.last !== rsp_last_unit) begin
                  $display("%0t: beat mismatch: expected unit %h last %b, actual unit %h last %b",
                           $time, want.unit, want.last, rsp_out_unit, rsp_last_unit);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) convert_unit(req_code_unit, req_end_of_text);
      end
   end

endmodule
`default_nettype wire

// ----- sim/tb_romaji_to_kana_stream_unit.sv -----
// Testbench top for romaji_to_kana_stream_unit: drives romaji text and random units.
// Depends on r2k_pkg, the unit under test and r2k_stream_checker.
`default_nettype none
module tb_romaji_to_kana_stream_unit;
   import r2k_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   unit_type req_code_unit = 16'h0000;
   logic     req_end_of_text = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b1;
   unit_type rsp_out_unit;
   logic     rsp_last_unit;
   int       mismatch_count;
   int       pending_kana;
   int       idle_cycles = 0;

   string syllables [] = '{"ka", "shi", "tsu", "chi", "n", "nya", "kyo", "ja", "fu",
                           "wi", "ye", "vu", "ve", "she", "tso", "fyu", "ryu", "o",
                           "na", "ni", "ha", "ma", "ge", "zo", "du", "pyo", "sya",
                           "tyu", "jyo", "zi", "e", "u", "-", "wo", "bi", "po"};

   always #5 clock = ~clock;

   romaji_to_kana_stream_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_unit    (rsp_out_unit),
      .rsp_last_unit   (rsp_last_unit)
   );

   r2k_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_unit    (rsp_out_unit),
      .rsp_last_unit   (rsp_last_unit),
      .mismatch_count  (mismatch_count),
      .pending_kana    (pending_kana)
   );

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offer one beat after a random gap and hold it until the block takes it.
   // Valid stays high across back-to-back beats.
   task automatic send_unit(input unit_type u, input logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_code_unit   <= u;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text(input string s, input bit eot);
      for (int i = 0; i < s.len(); i++) begin
         send_unit(unit_type'(s[i]), eot && (i == s.len() - 1));
      end
   endtask

   // Random casing of ASCII letters so the block must fold case.
   function automatic string shuffle_case(input string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++) begin
         if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 3) == 0) r[i] = r[i] - 8'h20;
      end
      return r;
   endfunction

   // Receiver: random stalls, one long hold-off so the block backs up into its input.
   initial begin
      int cycles;
      cycles = 0;
      @(negedge reset);
      while (1) begin
         int gap;
         int run;
         gap = pick_gap();
         if (cycles > 400 && cycles < 2000) begin
            gap = 150;
            cycles = 2000;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         run = $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         cycles += gap + run;
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sent;
      string word;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: doubling, case folding, long keys, bare n runs, hyphen, field extremes.
      send_text("KiTTe", 1);
      send_text("nnnn", 1);          // flush with only dropped n: no last marker
      send_text("shinbun-", 1);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'h0000, 1'b0);
      send_text("tsa", 1);
      send_text("n", 1);             // flush on a short window

      // Random: mostly romaji words, some noise units and broken strings.
      sent = 0;
      while (sent < 260) begin
         word = "";
         repeat ($urandom_range(1, 4)) begin
            string syl;
            syl = syllables[$urandom_range(0, syllables.size() - 1)];
            if ($urandom_range(0, 5) == 0 && syl != "n") syl = {syl.substr(0, 0), syl};
            word = {word, syl};
         end
         word = shuffle_case(word);
         for (int i = 0; i < word.len(); i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_unit(unit_type'($urandom_range(0, 16'hFFFF)), 1'b0);
               sent++;
            end
            send_unit(unit_type'(word[i]), (i == word.len() - 1) && $urandom_range(0, 4) != 0);
            sent++;
         end
      end
      send_unit(unit_type'("a"), 1'b1);
      req_valid <= 1'b0;

      // Drain: wait for every predicted beat, then let the pipeline settle.
      while (pending_kana != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
